FILE: sv/ptnst_pkg.sv
package ptnst_pkg;

	// opcodes of an input beat
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_SAMPLE = 2'd1;
	localparam logic [1:0] OP_LOAD   = 2'd2;

	// length load targets
	localparam logic [1:0] CH_PULSE1 = 2'd0;
	localparam logic [1:0] CH_PULSE2 = 2'd1;
	localparam logic [1:0] CH_NOISE  = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] REG_P1_CTRL   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_P1_PERIOD = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_P2_CTRL   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_P2_PERIOD = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TRI_PERIOD = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NZ_CTRL   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_NZ_PERIOD = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_EN_MODE   = 4'd7;

	localparam int TIMER_W = 13;

	// frame sequencer points
	localparam logic [8:0] LEN_LINE_A  = 9'd65;
	localparam logic [8:0] LEN_LINE_B  = 9'd196;
	localparam logic [8:0] FIVE_LINE_A = 9'd52;
	localparam logic [8:0] FIVE_LINE_B = 9'd209;
	localparam logic [8:0] LEN_DOT_LIMIT = 9'd6;

	localparam logic [10:0] PULSE1_MIN_PERIOD = 11'd8;
	localparam logic [14:0] NOISE_SHIFT_INIT  = 15'h0001;

	// mix weights
	localparam int W_PULSE = 75;
	localparam int W_TRI   = 85;
	localparam int W_NOISE = 50;

	typedef struct packed {
		logic [6:0]  p1_ctrl;
		logic [10:0] p1_period;
		logic [6:0]  p2_ctrl;
		logic [10:0] p2_period;
		logic [10:0] tri_period;
		logic [5:0]  nz_ctrl;
		logic [11:0] nz_period;
		logic [4:0]  en_mode;
	} cfg_t;

	typedef struct packed {
		logic [3:0] p1;
		logic [3:0] p2;
		logic [3:0] tri_lvl;
		logic [3:0] nz;
	} levels_t;

	function automatic logic [7:0] duty_init(input logic [1:0] sel);
		logic [7:0] v;
		case (sel)
			2'd0:    v = 8'h01;
			2'd1:    v = 8'h03;
			2'd2:    v = 8'h0F;
			default: v = 8'h03;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] length_lookup(input logic [4:0] idx);
		logic [7:0] v;
		case (idx)
			5'd0:  v = 8'd10;  5'd1:  v = 8'd254; 5'd2:  v = 8'd20;  5'd3:  v = 8'd2;
			5'd4:  v = 8'd40;  5'd5:  v = 8'd4;   5'd6:  v = 8'd80;  5'd7:  v = 8'd6;
			5'd8:  v = 8'd160; 5'd9:  v = 8'd8;   5'd10: v = 8'd60;  5'd11: v = 8'd10;
			5'd12: v = 8'd14;  5'd13: v = 8'd12;  5'd14: v = 8'd26;  5'd15: v = 8'd14;
			5'd16: v = 8'd12;  5'd17: v = 8'd16;  5'd18: v = 8'd24;  5'd19: v = 8'd18;
			5'd20: v = 8'd48;  5'd21: v = 8'd20;  5'd22: v = 8'd96;  5'd23: v = 8'd22;
			5'd24: v = 8'd192; 5'd25: v = 8'd24;  5'd26: v = 8'd72;  5'd27: v = 8'd26;
			5'd28: v = 8'd16;  5'd29: v = 8'd28;  5'd30: v = 8'd32;  default: v = 8'd30;
		endcase
		return v;
	endfunction

	// 15 down to 0, then 0 up to 15
	function automatic logic [3:0] tri_lookup(input logic [4:0] step);
		return step[4] ? step[3:0] : ~step[3:0];
	endfunction

endpackage

FILE: sv/pulse_triangle_noise_sound_tick.sv
// Four-voice sound unit (two pulse, triangle, noise) stepped by video timing.
// Each beat is a tick, a sample request, a length load or a no-op; only a sample
// request returns a beat, carrying the weighted voice mix. A beat is captured
// in an input register and handled from there, one beat per cycle while no
// sample request is held: voice timers, duty patterns, the noise shifter and
// the length counters update in that one step, and the mix lands in an output
// register. in_stall rises only when a sample request waits behind an untaken
// sample at the output. Configuration must be written through cfg_we/cfg_index/
// cfg_data only while idle; the block does not enforce this. Indexes above 7
// are ignored.
module pulse_triangle_noise_sound_tick
	import ptnst_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            opcode,
	input  logic [8:0]            scanline,
	input  logic [8:0]            dot,
	input  logic [1:0]            length_channel,
	input  logic [4:0]            length_index,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [12:0]           mixed_sample
);

	cfg_t cfg_q;
	levels_t levels;
	logic [12:0] mixed;

	logic       valid_s1;
	logic [1:0] opcode_s1;
	logic [8:0] scanline_s1, dot_s1;
	logic [1:0] chan_s1;
	logic [4:0] idx_s1;
	logic       adv_s1, accept, out_valid_q;
	logic [12:0] sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_P1_CTRL:    cfg_q.p1_ctrl    <= cfg_data[6:0];
				REG_P1_PERIOD:  cfg_q.p1_period  <= cfg_data[10:0];
				REG_P2_CTRL:    cfg_q.p2_ctrl    <= cfg_data[6:0];
				REG_P2_PERIOD:  cfg_q.p2_period  <= cfg_data[10:0];
				REG_TRI_PERIOD: cfg_q.tri_period <= cfg_data[10:0];
				REG_NZ_CTRL:    cfg_q.nz_ctrl    <= cfg_data[5:0];
				REG_NZ_PERIOD:  cfg_q.nz_period  <= cfg_data[11:0];
				REG_EN_MODE:    cfg_q.en_mode    <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// only a sample beat needs room at the output
	assign adv_s1 = valid_s1 && (opcode_s1 != OP_SAMPLE || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1   <= opcode;
			scanline_s1 <= scanline;
			dot_s1      <= dot;
			chan_s1     <= length_channel;
			idx_s1      <= length_index;
		end
	end

	ptnst_voices u_voices (
		.clk            (clk),
		.arst_n         (arst_n),
		.step_en        (adv_s1),
		.opcode         (opcode_s1),
		.scanline       (scanline_s1),
		.dot            (dot_s1),
		.length_channel (chan_s1),
		.length_index   (idx_s1),
		.cfg            (cfg_q),
		.levels         (levels)
	);

	ptnst_mix u_mix (
		.levels (levels),
		.mixed  (mixed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && opcode_s1 == OP_SAMPLE) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && opcode_s1 == OP_SAMPLE) begin
			sample_q <= mixed;
		end
	end

	assign out_valid    = out_valid_q;
	assign mixed_sample = sample_q;

endmodule

FILE: sv/ptnst_pulse.sv
module ptnst_pulse
	import ptnst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tick,
	input  logic        len_clk,
	input  logic        load,
	input  logic [7:0]  load_val,
	input  logic [6:0]  ctrl,
	input  logic [10:0] period,
	output logic        duty_bit,
	output logic        len_nz
);

	logic signed [TIMER_W-1:0] timer_q;
	logic signed [TIMER_W-1:0] timer_dec;
	logic [7:0] pat_q [4];
	logic [7:0] len_q;
	logic [1:0] duty_sel;
	logic       reload;

	assign duty_sel  = ctrl[6:5];
	assign timer_dec = timer_q - 13'sd1;
	assign reload    = timer_dec <= 13'sd0;
	assign duty_bit  = pat_q[duty_sel][0];
	assign len_nz    = len_q != 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= '0;
			len_q   <= '0;
			for (int i = 0; i < 4; i++) begin
				pat_q[i] <= duty_init(2'(i));
			end
		end else begin
			if (tick) begin
				if (reload) begin
					timer_q <= $signed({2'b00, period});
					pat_q[duty_sel] <= {pat_q[duty_sel][0], pat_q[duty_sel][7:1]};
				end else begin
					timer_q <= timer_dec;
				end
				// halt in bit 4, counter sticks at zero
				if (len_clk && len_nz && !ctrl[4]) begin
					len_q <= len_q - 8'd1;
				end
			end
			if (load) begin
				len_q <= load_val;
			end
		end
	end

endmodule

FILE: sv/ptnst_voices.sv
module ptnst_voices
	import ptnst_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_en,
	input  logic [1:0] opcode,
	input  logic [8:0] scanline,
	input  logic [8:0] dot,
	input  logic [1:0] length_channel,
	input  logic [4:0] length_index,
	input  cfg_t       cfg,
	output levels_t    levels
);

	logic tick, load, len_clk;
	logic [7:0] load_val;
	logic p1_bit, p1_nz, p2_bit, p2_nz;

	logic signed [TIMER_W-1:0] tri_timer_q, tri_dec;
	logic [4:0] tri_step_q;
	logic signed [TIMER_W-1:0] nz_timer_q, nz_dec;
	logic [14:0] nz_shift_q;
	logic [7:0] nz_len_q;
	logic nz_fb, nz_len_nz;

	assign tick     = step_en && opcode == OP_TICK;
	assign load     = step_en && opcode == OP_LOAD;
	assign load_val = length_lookup(length_index);

	always_comb begin
		if (dot >= LEN_DOT_LIMIT) begin
			len_clk = 1'b0;
		end else if (cfg.en_mode[4]) begin
			len_clk = scanline == FIVE_LINE_A || scanline == FIVE_LINE_B;
		end else begin
			len_clk = scanline == LEN_LINE_A || scanline == LEN_LINE_B;
		end
	end

	ptnst_pulse u_pulse1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick),
		.len_clk  (len_clk),
		.load     (load && length_channel == CH_PULSE1),
		.load_val (load_val),
		.ctrl     (cfg.p1_ctrl),
		.period   (cfg.p1_period),
		.duty_bit (p1_bit),
		.len_nz   (p1_nz)
	);

	ptnst_pulse u_pulse2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick),
		.len_clk  (len_clk),
		.load     (load && length_channel == CH_PULSE2),
		.load_val (load_val),
		.ctrl     (cfg.p2_ctrl),
		.period   (cfg.p2_period),
		.duty_bit (p2_bit),
		.len_nz   (p2_nz)
	);

	assign tri_dec   = tri_timer_q - 13'sd2;
	assign nz_dec    = nz_timer_q - 13'sd1;
	assign nz_fb     = nz_shift_q[0] ^ (cfg.nz_ctrl[5] ? nz_shift_q[6] : nz_shift_q[1]);
	assign nz_len_nz = nz_len_q != 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tri_timer_q <= '0;
			tri_step_q  <= '0;
			nz_timer_q  <= '0;
			nz_shift_q  <= NOISE_SHIFT_INIT;
			nz_len_q    <= '0;
		end else begin
			if (tick) begin
				if (tri_dec <= 13'sd0) begin
					tri_timer_q <= $signed({2'b00, cfg.tri_period});
					tri_step_q  <= tri_step_q + 5'd1;
				end else begin
					tri_timer_q <= tri_dec;
				end
				// noise reloads only once the timer goes negative
				if (nz_dec[TIMER_W-1]) begin
					nz_timer_q <= $signed({1'b0, cfg.nz_period});
					nz_shift_q <= {nz_fb, nz_shift_q[14:1]};
				end else begin
					nz_timer_q <= nz_dec;
				end
				if (len_clk && nz_len_nz && !cfg.nz_ctrl[4]) begin
					nz_len_q <= nz_len_q - 8'd1;
				end
			end
			if (load && length_channel == CH_NOISE) begin
				nz_len_q <= load_val;
			end
		end
	end

	always_comb begin
		levels = '0;
		if (cfg.en_mode[0] && cfg.p1_period >= PULSE1_MIN_PERIOD && p1_nz && p1_bit) begin
			levels.p1 = cfg.p1_ctrl[3:0];
		end
		if (cfg.en_mode[1] && p2_nz && p2_bit) begin
			levels.p2 = cfg.p2_ctrl[3:0];
		end
		if (cfg.en_mode[2]) begin
			levels.tri_lvl = tri_lookup(tri_step_q);
		end
		if (cfg.en_mode[3] && nz_len_nz && nz_shift_q[0]) begin
			levels.nz = cfg.nz_ctrl[3:0];
		end
	end

endmodule

FILE: sv/ptnst_mix.sv
module ptnst_mix
	import ptnst_pkg::*;
(
	input  levels_t     levels,
	output logic [12:0] mixed
);

	logic [4:0]  pulse_sum;
	logic [12:0] pulse_part, tri_part, nz_part;

	assign pulse_sum  = {1'b0, levels.p1} + {1'b0, levels.p2};
	assign pulse_part = 13'(32'(pulse_sum) * W_PULSE);
	assign tri_part   = 13'(32'(levels.tri_lvl) * W_TRI);
	assign nz_part    = 13'(32'(levels.nz) * W_NOISE);
	assign mixed      = pulse_part + tri_part + nz_part;

endmodule

FILE: tb/sv/sound_mix_check_pkg.sv
package sound_mix_check_pkg;
	import ptnst_pkg::*;

	// tracks voice state from accepted beats and holds the mixes still owed
	class sound_mix_scoreboard;
		bit [6:0]  p1_ctrl, p2_ctrl;
		bit [10:0] p1_per, p2_per, tri_per;
		bit [5:0]  nz_ctrl;
		bit [11:0] nz_per;
		bit [4:0]  en_mode;
		bit [7:0]  p1_pat[4];
		bit [7:0]  p2_pat[4];
		int        p1_tmr, p2_tmr, tri_tmr, nz_tmr;
		bit [4:0]  tri_step;
		bit [14:0] lfsr;
		bit [7:0]  p1_len, p2_len, nz_len;
		bit [7:0]  len_tab[32];
		bit [12:0] expected_mixes[$];
		int        errors;

		function new();
			len_tab = '{10, 254, 20, 2, 40, 4, 80, 6, 160, 8, 60, 10, 14, 12, 26, 14,
				12, 16, 24, 18, 48, 20, 96, 22, 192, 24, 72, 26, 16, 28, 32, 30};
			p1_pat = '{8'h01, 8'h03, 8'h0F, 8'h03};
			p2_pat = '{8'h01, 8'h03, 8'h0F, 8'h03};
			lfsr = NOISE_SHIFT_INIT;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				REG_P1_CTRL:    p1_ctrl = d[6:0];
				REG_P1_PERIOD:  p1_per = d[10:0];
				REG_P2_CTRL:    p2_ctrl = d[6:0];
				REG_P2_PERIOD:  p2_per = d[10:0];
				REG_TRI_PERIOD: tri_per = d[10:0];
				REG_NZ_CTRL:    nz_ctrl = d[5:0];
				REG_NZ_PERIOD:  nz_per = d[11:0];
				REG_EN_MODE:    en_mode = d[4:0];
				default: ;
			endcase
		endfunction

		function void step_pulse(inout int tmr, input bit [10:0] per, inout bit [7:0] pat);
			tmr -= 1;
			if (tmr <= 0) begin
				tmr = int'(per);
				pat = {pat[0], pat[7:1]};
			end
		endfunction

		function bit [7:0] length_step(bit [7:0] len, bit halt, bit len_clk);
			return (len_clk && len != 0 && !halt) ? len - 8'd1 : len;
		endfunction

		function void note_beat(logic [1:0] op, logic [8:0] sl, logic [8:0] dt,
				logic [1:0] ch, logic [4:0] idx);
			bit len_clk;
			bit fb;
			int p1, p2, tr, nz;
			if (en_mode[4])
				len_clk = (dt < LEN_DOT_LIMIT) && (sl == FIVE_LINE_A || sl == FIVE_LINE_B);
			else
				len_clk = (dt < LEN_DOT_LIMIT) && (sl == LEN_LINE_A || sl == LEN_LINE_B);
			case (op)
				OP_TICK: begin
					step_pulse(p1_tmr, p1_per, p1_pat[p1_ctrl[6:5]]);
					p1_len = length_step(p1_len, p1_ctrl[4], len_clk);
					step_pulse(p2_tmr, p2_per, p2_pat[p2_ctrl[6:5]]);
					p2_len = length_step(p2_len, p2_ctrl[4], len_clk);
					tri_tmr -= 2;
					if (tri_tmr <= 0) begin
						tri_tmr = int'(tri_per);
						tri_step += 5'd1;
					end
					begin : tmr_noise
						nz_tmr -= 1;
						if (nz_tmr < 0) begin
							// short mode taps bit 6 instead of bit 1
							fb = lfsr[0] ^ (nz_ctrl[5] ? lfsr[6] : lfsr[1]);
							nz_tmr = int'(nz_per);
							lfsr = {fb, lfsr[14:1]};
						end
					end
					nz_len = length_step(nz_len, nz_ctrl[4], len_clk);
				end
				OP_SAMPLE: begin
					p1 = 0;
					p2 = 0;
					tr = 0;
					nz = 0;
					if (en_mode[0] && p1_per >= PULSE1_MIN_PERIOD && p1_len != 0)
						p1 = p1_pat[p1_ctrl[6:5]][0] ? int'(p1_ctrl[3:0]) : 0;
					if (en_mode[1] && p2_len != 0)
						p2 = p2_pat[p2_ctrl[6:5]][0] ? int'(p2_ctrl[3:0]) : 0;
					if (en_mode[2])
						tr = (tri_step < 16) ? 15 - int'(tri_step) : int'(tri_step) - 16;
					if (en_mode[3] && nz_len != 0)
						nz = lfsr[0] ? int'(nz_ctrl[3:0]) : 0;
					expected_mixes.push_back(13'((p1 + p2) * W_PULSE + tr * W_TRI
						+ nz * W_NOISE));
				end
				OP_LOAD: begin
					case (ch)
						CH_PULSE1: p1_len = len_tab[idx];
						CH_PULSE2: p2_len = len_tab[idx];
						CH_NOISE:  nz_len = len_tab[idx];
						default: ;
					endcase
				end
				default: ;
			endcase
		endfunction

		function void check_sample(logic [12:0] got);
			bit [12:0] want;
			if (expected_mixes.size() == 0) begin
				$error("mixed_sample: expected nothing, actual %0d", got);
				errors++;
				return;
			end
			want = expected_mixes.pop_front();
			if (got !== want) begin
				$error("mixed_sample: expected %0d, actual %0d", want, got);
				errors++;
			end
		endfunction

		function int pending();
			return expected_mixes.size();
		endfunction
	endclass

endpackage

FILE: tb/sv/pulse_triangle_noise_sound_tick_tb.sv
module pulse_triangle_noise_sound_tick_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ptnst_pkg::*;
	import sound_mix_check_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [1:0] CH_UNUSED = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            opcode;
	logic [8:0]            scanline;
	logic [8:0]            dot;
	logic [1:0]            length_channel;
	logic [4:0]            length_index;
	logic                  out_valid;
	logic                  out_stall;
	logic [12:0]           mixed_sample;

	sound_mix_scoreboard sb;
	int idle_pct;
	int stall_pct;
	int hold_left;

	pulse_triangle_noise_sound_tick dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.scanline       (scanline),
		.dot            (dot),
		.length_channel (length_channel),
		.length_index   (length_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.mixed_sample   (mixed_sample)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// output side: a long hold when asked, otherwise random stalls
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_sample(mixed_sample);
	end

	task automatic send_beat(logic [1:0] op, logic [8:0] sl, logic [8:0] dt,
			logic [1:0] ch, logic [4:0] idx);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		scanline <= sl;
		dot <= dt;
		length_channel <= ch;
		length_index <= idx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_beat(op, sl, dt, ch, idx);
	endtask

	task automatic rand_beat();
		logic [1:0] op;
		logic [8:0] sl;
		logic [8:0] dt;
		logic [1:0] ch;
		int r;
		r = $urandom_range(99);
		op = (r < 55) ? OP_TICK : (r < 80) ? OP_SAMPLE : (r < 96) ? OP_LOAD : OP_UNUSED;
		// favor the frame sequencer lines so length counters actually move
		if ($urandom_range(9) < 4) begin
			case ($urandom_range(3))
				0:       sl = FIVE_LINE_A;
				1:       sl = LEN_LINE_A;
				2:       sl = LEN_LINE_B;
				default: sl = FIVE_LINE_B;
			endcase
		end else begin
			sl = 9'($urandom_range(0, 511));
		end
		dt = $urandom_range(1) ? 9'($urandom_range(0, 7)) : 9'($urandom_range(0, 511));
		ch = ($urandom_range(9) == 0) ? CH_UNUSED : 2'($urandom_range(0, 2));
		send_beat(op, sl, dt, ch, 5'($urandom_range(0, 31)));
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		sb.write_reg(idx, d);
	endtask

	task automatic cfg_close();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// ticks leave nothing to wait for, so give the pipeline time to empty
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] rand_period();
		return ($urandom_range(9) < 7) ? CFG_DATA_W'($urandom_range(0, 20))
			: CFG_DATA_W'($urandom_range(0, 4095));
	endfunction

	initial begin
		int waited;
		logic [CFG_DATA_W-1:0] v;
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_P1_CTRL;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = OP_TICK;
		scanline = '0;
		dot = '0;
		length_channel = CH_PULSE1;
		length_index = '0;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		waited = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		cfg_write(REG_P1_CTRL, 12'h04F);
		cfg_write(REG_P1_PERIOD, 12'd8);   // lowest period that still sounds
		cfg_write(REG_P2_CTRL, 12'h069);
		cfg_write(REG_P2_PERIOD, 12'd3);
		cfg_write(REG_TRI_PERIOD, 12'd4);
		cfg_write(REG_NZ_CTRL, 12'h02C);
		cfg_write(REG_NZ_PERIOD, 12'd2);
		cfg_write(REG_EN_MODE, 12'h00F);
		cfg_write({CFG_IDX_W{1'b1}}, 12'hFFF);
		cfg_close();

		send_beat(OP_SAMPLE, 9'd0, 9'd0, CH_PULSE1, 5'd0);
		send_beat(OP_LOAD, 9'd0, 9'd0, CH_PULSE1, 5'd1);
		send_beat(OP_LOAD, 9'd0, 9'd0, CH_PULSE2, 5'd0);
		send_beat(OP_LOAD, 9'd0, 9'd0, CH_NOISE, 5'd31);
		send_beat(OP_LOAD, 9'd0, 9'd0, CH_UNUSED, 5'd31);
		send_beat(OP_UNUSED, 9'd511, 9'd511, CH_UNUSED, 5'd31);
		send_beat(OP_SAMPLE, 9'd0, 9'd0, CH_PULSE1, 5'd0);
		send_beat(OP_TICK, LEN_LINE_A, 9'd0, CH_PULSE1, 5'd0);
		send_beat(OP_TICK, LEN_LINE_A, 9'd5, CH_PULSE1, 5'd0);
		send_beat(OP_TICK, LEN_LINE_A, LEN_DOT_LIMIT, CH_PULSE1, 5'd0);
		send_beat(OP_TICK, LEN_LINE_B, 9'd511, CH_PULSE1, 5'd0);
		send_beat(OP_TICK, FIVE_LINE_A, 9'd0, CH_UNUSED, 5'd31);
		send_beat(OP_TICK, 9'd511, 9'd0, CH_PULSE1, 5'd0);
		send_beat(OP_SAMPLE, 9'd0, 9'd0, CH_PULSE1, 5'd0);
		// length of two runs out and must then hold at zero
		send_beat(OP_LOAD, 9'd0, 9'd0, CH_PULSE1, 5'd3);
		send_beat(OP_TICK, LEN_LINE_A, 9'd0, CH_PULSE1, 5'd0);
		send_beat(OP_TICK, LEN_LINE_B, 9'd1, CH_PULSE1, 5'd0);
		send_beat(OP_TICK, LEN_LINE_A, 9'd2, CH_PULSE1, 5'd0);
		send_beat(OP_SAMPLE, 9'd0, 9'd0, CH_PULSE1, 5'd0);
		settle();

		// five-step frame, halts set on pulse one and noise, pulse one muted by a short period
		cfg_write(REG_P1_CTRL, 12'h07A);
		cfg_write(REG_P1_PERIOD, 12'd7);
		cfg_write(REG_P2_CTRL, 12'h005);
		cfg_write(REG_NZ_CTRL, 12'h017);
		cfg_write(REG_EN_MODE, 12'h01B);
		cfg_close();
		send_beat(OP_LOAD, 9'd0, 9'd0, CH_PULSE2, 5'd3);
		send_beat(OP_LOAD, 9'd0, 9'd0, CH_NOISE, 5'd5);
		send_beat(OP_TICK, FIVE_LINE_A, 9'd0, CH_PULSE1, 5'd0);
		send_beat(OP_TICK, FIVE_LINE_B, 9'd2, CH_PULSE1, 5'd0);
		send_beat(OP_TICK, LEN_LINE_A, 9'd0, CH_PULSE1, 5'd0);
		send_beat(OP_SAMPLE, 9'd0, 9'd0, CH_PULSE1, 5'd0);

		for (int ph = 0; ph < 12; ph++) begin
			settle();
			for (int r = REG_P1_CTRL; r <= REG_EN_MODE; r++) begin
				if (ph == 0)
					v = '0;
				else if (ph == 1)
					v = '1;
				else if (r == REG_P1_PERIOD || r == REG_P2_PERIOD || r == REG_TRI_PERIOD
						|| r == REG_NZ_PERIOD)
					v = rand_period();
				else
					v = CFG_DATA_W'($urandom_range(0, 4095));
				cfg_write(CFG_IDX_W'(r), v);
			end
			if (ph > 1 && $urandom_range(1))
				cfg_write(CFG_IDX_W'($urandom_range(8, 15)), CFG_DATA_W'($urandom_range(0, 4095)));
			cfg_close();
			idle_pct = (ph % 4 == 1) ? 60 : (ph % 4 == 3) ? 18 : 0;
			stall_pct = (ph % 4 == 2) ? 60 : (ph % 4 == 3) ? 18 : 0;
			// long output hold while beats keep coming, to back the block up
			if (ph == 2)
				hold_left = 300;
			repeat (118) rand_beat();
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (6) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("mixed_sample: %0d expected beats never arrived", sb.pending());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
